FILE: rtl/diff_drive_odometry_top_macros.svh
// ----------------------------------------------------------------------------
// diff_drive_odometry_top_macros
// Assertion macros shared by the odometry block.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_TOP_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_TOP_MACROS_SVH

// same-cycle implication
`define DDO_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Types and constants of the differential drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int COUNT_BITS = 16;
    localparam int WRAP_W     = 39;

    // angle constants, Q3.28
    localparam logic [WRAP_W-1:0] PI_W     = 39'd843314857;
    localparam logic [WRAP_W-1:0] TWO_PI_W = 39'd1686629714;
    // 129*pi: makes any tick's angle sum positive before reduction
    localparam logic [WRAP_W-1:0] BIAS_W   = 39'd108787616553;
    localparam logic signed [31:0] PI_S    = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI = 32'sd421657428;
    localparam logic signed [33:0] GAIN    = 34'sd652032874;

    localparam logic [4:0] WRAP_TOP  = 5'd6;
    localparam logic [4:0] MULT_LAST = 5'd4;

    // configuration register indexes
    localparam logic [1:0] REG_DISTANCE = 2'd0;
    localparam logic [1:0] REG_HEADING  = 2'd1;
    localparam logic [1:0] REG_WEIGHT   = 2'd2;
    localparam logic [1:0] REG_INTERVAL = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_HSTEP, S_WRAP_ODO, S_LOAD_IMU, S_WRAP_IMU, S_BLEND,
        S_FOLD, S_ROTATE, S_SIGN, S_MULT, S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_CAPTURE, OP_HSTEP, OP_WRAP_STEP, OP_ODO_STORE,
        OP_BLEND, OP_FOLD, OP_ROTATE, OP_SIGN, OP_MULT, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] idx;
    } t_cmd;

    typedef struct packed {
        logic emit;      // this tick produces a pose
        logic out_busy;  // output register full and stalled
    } t_stat;

    // 2*pi scaled by 2^k
    function automatic logic [WRAP_W-1:0] wrap_step(input logic [2:0] k);
        return TWO_PI_W << k;
    endfunction

    // arctangent table, 2^-30 rad, truncated
    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:  v = 34'sd843314856;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043836;
            5'd3:  v = 34'sd133525158;
            5'd4:  v = 34'sd67021686;
            5'd5:  v = 34'sd33543515;
            5'd6:  v = 34'sd16775850;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194282;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048575;
            5'd11: v = 34'sd524287;
            5'd12: v = 34'sd262143;
            5'd13: v = 34'sd131071;
            5'd14: v = 34'sd65535;
            5'd15: v = 34'sd32767;
            5'd16: v = 34'sd16383;
            5'd17: v = 34'sd8191;
            5'd18: v = 34'sd4095;
            5'd19: v = 34'sd2047;
            5'd20: v = 34'sd1023;
            5'd21: v = 34'sd511;
            5'd22: v = 34'sd255;
            5'd23: v = 34'sd127;
            5'd24: v = 34'sd63;
            5'd25: v = 34'sd31;
            5'd26: v = 34'sd15;
            5'd27: v = 34'sd7;
            5'd28: v = 34'sd3;
            5'd29: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/diff_drive_odometry_top.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry_top
// Differential drive wheel odometry with IMU heading blend.
// ----------------------------------------------------------------------------
// Use: each item on the slave stream is one tick: two free-running 16-bit
// wheel counters and an IMU yaw (Q3.28 rad). Wrapped count deltas drive an
// odometry heading; it is blended with the IMU yaw, and x/y advance by the
// mean wheel travel along the blended heading (cos/sin from a CORDIC).
// Every report_interval ticks one pose item (x, y Q16.16 m, heading Q3.28)
// leaves on the master stream; other ticks give no item.
// Timing: one tick at a time. A tick's time from acceptance to the pose
// register is set mainly by the iterative CORDIC and the two seven-step
// angle reductions; tready is high again in the cycle after the emit step,
// so a new tick is not taken before the one in flight is through.
// The pose sits in an output register, so the next tick is taken while a
// pose waits; only a tick that must emit stalls if the old pose is unread.
// Reset (synchronous, active low): position, heading, counter history and
// report phase clear; registers return to their default values.
// Configuration: write only while idle; index 0..3 as listed in ddo_pkg.
// ----------------------------------------------------------------------------
`include "diff_drive_odometry_top_macros.svh"

module diff_drive_odometry_top #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // right_count[15:0], left_count[31:16],
                                        // imu_heading[63:32]
    // pose out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // x_position[31:0], y_position[63:32],
                                        // heading[94:64], zero[95]
    // configuration write
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_data
);
    import ddo_pkg::*;

    // configuration registers
    logic [23:0] r_distance_per_count, r_heading_per_count;
    logic [8:0]  r_imu_weight;
    logic [7:0]  r_report_interval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distance_per_count <= 24'd168663;
            r_heading_per_count  <= 24'd337326;
            r_imu_weight         <= 9'd256;
            r_report_interval    <= 8'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_DISTANCE: r_distance_per_count <= i_cfg_data;
                REG_HEADING:  r_heading_per_count  <= i_cfg_data;
                REG_WEIGHT:   r_imu_weight         <= i_cfg_data[8:0];
                REG_INTERVAL: r_report_interval    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    t_cmd  cmd;
    t_stat stat;

    ddo_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    logic signed [31:0] x_pos, y_pos;
    logic signed [30:0] hdg;

    ddo_datapath u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_right_count        (s_axis_tdata[15:0]),
        .i_left_count         (s_axis_tdata[31:16]),
        .i_imu_heading        (s_axis_tdata[63:32]),
        .i_distance_per_count (r_distance_per_count),
        .i_heading_per_count  (r_heading_per_count),
        .i_imu_weight         (r_imu_weight),
        .i_report_interval    (r_report_interval),
        .i_out_ready          (m_axis_tready),
        .o_out_valid          (m_axis_tvalid),
        .o_x_position         (x_pos),
        .o_y_position         (y_pos),
        .o_heading            (hdg)
    );

    assign m_axis_tdata = {1'b0, hdg, y_pos, x_pos};

    logic tick_acc, hdg_ok;
    assign tick_acc = s_axis_tvalid && s_axis_tready;
    assign hdg_ok   = (hdg >= -31'sd843314857) && (hdg <= 31'sd843314856);

    // one tick in flight at a time
    `DDO_ASSERT_NEXT(a_single_tick, i_clk, i_rst_n, tick_acc, !s_axis_tready, "tick taken while busy")
    // emitted heading is a wrapped angle
    `DDO_ASSERT_NOW(a_heading_range, i_clk, i_rst_n, m_axis_tvalid, hdg_ok, "heading out of range")

endmodule

FILE: rtl/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// ddo_ctrl
// Sequencer for one odometry tick.
// ----------------------------------------------------------------------------
module ddo_ctrl #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ddo_pkg::t_stat i_stat,
    output ddo_pkg::t_cmd  o_cmd
);
    import ddo_pkg::*;

    localparam logic [4:0] STEPS_LAST = 5'(CORDIC_STEPS - 1);

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_HSTEP;
            S_HSTEP: begin
                n_state = S_WRAP_ODO;
                n_cnt   = WRAP_TOP;
            end
            S_WRAP_ODO: begin
                if (r_cnt == 5'd0) n_state = S_LOAD_IMU;
                else n_cnt = r_cnt - 5'd1;
            end
            S_LOAD_IMU: begin
                n_state = S_WRAP_IMU;
                n_cnt   = WRAP_TOP;
            end
            S_WRAP_IMU: begin
                if (r_cnt == 5'd0) n_state = S_BLEND;
                else n_cnt = r_cnt - 5'd1;
            end
            S_BLEND:    n_state = S_FOLD;
            S_FOLD: begin
                n_state = S_ROTATE;
                n_cnt   = '0;
            end
            S_ROTATE: begin
                if (r_cnt == STEPS_LAST) n_state = S_SIGN;
                else n_cnt = r_cnt + 5'd1;
            end
            S_SIGN: begin
                n_state = S_MULT;
                n_cnt   = '0;
            end
            S_MULT: begin
                if (r_cnt == MULT_LAST) n_state = S_EMIT;
                else n_cnt = r_cnt + 5'd1;
            end
            S_EMIT:     if (!(i_stat.emit && i_stat.out_busy)) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        o_cmd.idx  = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_CAPTURE;
            end
            S_HSTEP:    o_cmd.op = OP_HSTEP;
            S_WRAP_ODO: o_cmd.op = OP_WRAP_STEP;
            S_LOAD_IMU: o_cmd.op = OP_ODO_STORE;
            S_WRAP_IMU: o_cmd.op = OP_WRAP_STEP;
            S_BLEND:    o_cmd.op = OP_BLEND;
            S_FOLD:     o_cmd.op = OP_FOLD;
            S_ROTATE:   o_cmd.op = OP_ROTATE;
            S_SIGN:     o_cmd.op = OP_SIGN;
            S_MULT:     o_cmd.op = OP_MULT;
            S_EMIT:     if (!(i_stat.emit && i_stat.out_busy)) o_cmd.op = OP_EMIT;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

endmodule

FILE: rtl/ddo_datapath.sv
// ----------------------------------------------------------------------------
// ddo_datapath
// Odometry state, angle reduction, blend, CORDIC and travel products.
// ----------------------------------------------------------------------------
module ddo_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ddo_pkg::t_cmd       i_cmd,
    output ddo_pkg::t_stat      o_stat,
    input  logic [15:0]         i_right_count,
    input  logic [15:0]         i_left_count,
    input  logic signed [31:0]  i_imu_heading,
    input  logic [23:0]         i_distance_per_count,
    input  logic [23:0]         i_heading_per_count,
    input  logic [8:0]          i_imu_weight,
    input  logic [7:0]          i_report_interval,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic signed [31:0]  o_x_position,
    output logic signed [31:0]  o_y_position,
    output logic signed [30:0]  o_heading
);
    import ddo_pkg::*;

    // control state
    logic [15:0]        r_prev_right, r_prev_left;
    logic signed [31:0] r_odo, r_pos_x, r_pos_y;
    logic [7:0]         r_phase;
    logic               r_out_valid;

    // working registers
    logic signed [31:0] r_imu, r_yaw;
    logic signed [16:0] r_diff, r_sum;
    logic [WRAP_W-1:0]  r_wr;
    logic               r_neg, r_mneg, r_cneg, r_sneg;
    logic signed [33:0] r_x, r_y, r_z;
    logic [40:0]        r_mmag;
    logic [33:0]        r_cmag, r_smag;
    logic [75:0]        r_acc;
    logic signed [31:0] r_out_x, r_out_y;
    logic signed [30:0] r_out_h;

    // capture
    logic signed [15:0] dr, dl;
    assign dr = i_right_count - r_prev_right;
    assign dl = i_left_count - r_prev_left;

    // heading step and angle reduction
    logic signed [41:0] hprod, hround, hsh;
    logic signed [38:0] odo_arg;
    logic [WRAP_W-1:0]  wstep, wdiff;
    logic signed [31:0] wrapped;
    assign hprod   = r_diff * $signed({1'b0, i_heading_per_count});
    assign hround  = hprod + 42'sd8;
    assign hsh     = hround >>> 4;
    assign odo_arg = {{7{r_odo[31]}}, r_odo} + hsh[38:0];
    assign wstep   = wrap_step(i_cmd.idx[2:0]);
    assign wdiff   = r_wr - PI_W;
    assign wrapped = wdiff[31:0];

    // blend: odo + w*(imu - odo)/256
    logic signed [32:0] bd;
    logic signed [9:0]  wcl;
    logic signed [42:0] bprod, bsh;
    assign bd    = {wrapped[31], wrapped} - {r_odo[31], r_odo};
    assign wcl   = (i_imu_weight > 9'd256) ? 10'sd256 : $signed({1'b0, i_imu_weight});
    assign bprod = bd * wcl;
    assign bsh   = bprod >>> 8;

    // fold and travel
    logic signed [31:0] ang;
    logic               fneg;
    logic signed [41:0] mprod;
    logic [41:0]        mabs;
    always_comb begin
        ang  = r_yaw;
        fneg = 1'b0;
        if (r_yaw > HALF_PI) begin
            ang  = r_yaw - PI_S;
            fneg = 1'b1;
        end else if (r_yaw < -HALF_PI) begin
            ang  = r_yaw + PI_S;
            fneg = 1'b1;
        end
    end
    assign mprod = r_sum * $signed({1'b0, i_distance_per_count});
    assign mabs  = mprod[41] ? -mprod : mprod;

    // rotation step
    logic signed [33:0] xs, ys, at;
    assign xs = r_x >>> i_cmd.idx;
    assign ys = r_y >>> i_cmd.idx;
    assign at = atan_q30(i_cmd.idx);

    // sign split
    logic signed [33:0] cval, sval, cabs, sabs;
    assign cval = r_neg ? -r_x : r_x;
    assign sval = r_neg ? -r_y : r_y;
    assign cabs = cval[33] ? -cval : cval;
    assign sabs = sval[33] ? -sval : sval;

    // partial products of |m| * |t|
    logic [20:0] part;
    logic [33:0] tmag;
    logic [54:0] pprod;
    logic [75:0] racc;
    logic [31:0] dmag, dx, dy;
    assign part  = i_cmd.idx[0] ? {1'b0, r_mmag[40:21]} : r_mmag[20:0];
    assign tmag  = i_cmd.idx[1] ? r_smag : r_cmag;
    assign pprod = part * tmag;
    assign racc  = r_acc + (76'd1 << 46);
    assign dmag  = {3'b000, racc[75:47]};
    assign dx    = (r_mneg ^ r_cneg) ? (~dmag + 32'd1) : dmag;
    assign dy    = (r_mneg ^ r_sneg) ? (~dmag + 32'd1) : dmag;

    // report phase
    logic [7:0] interval, n_phase;
    logic       emit;
    assign interval = (i_report_interval == 8'd0) ? 8'd1 : i_report_interval;
    assign n_phase  = r_phase + 8'd1;
    assign emit     = (n_phase >= interval);
    assign o_stat.emit     = emit;
    assign o_stat.out_busy = r_out_valid & ~i_out_ready;

    logic load_out;
    assign load_out = (i_cmd.op == OP_EMIT) && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_right <= '0;
            r_prev_left  <= '0;
            r_odo        <= '0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_phase      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.op == OP_CAPTURE) begin
                r_prev_right <= i_right_count;
                r_prev_left  <= i_left_count;
            end
            if (i_cmd.op == OP_ODO_STORE) r_odo <= wrapped;
            if (i_cmd.op == OP_MULT) begin
                if (i_cmd.idx == 5'd2) r_pos_x <= r_pos_x + dx;
                if (i_cmd.idx == MULT_LAST) r_pos_y <= r_pos_y + dy;
            end
            if (i_cmd.op == OP_EMIT) r_phase <= emit ? 8'd0 : n_phase;
            if (load_out) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_imu  <= i_imu_heading;
                r_diff <= {dr[15], dr} - {dl[15], dl};
                r_sum  <= {dr[15], dr} + {dl[15], dl};
            end
            OP_HSTEP:     r_wr <= odo_arg + BIAS_W;
            OP_WRAP_STEP: if (r_wr >= wstep) r_wr <= r_wr - wstep;
            OP_ODO_STORE: r_wr <= {{7{r_imu[31]}}, r_imu} + BIAS_W;
            OP_BLEND:     r_yaw <= r_odo + bsh[31:0];
            OP_FOLD: begin
                r_neg  <= fneg;
                r_z    <= {ang, 2'b00};
                r_x    <= GAIN;
                r_y    <= '0;
                r_mneg <= mprod[41];
                r_mmag <= mabs[40:0];
            end
            OP_ROTATE: begin
                if (!r_z[33]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
            end
            OP_SIGN: begin
                r_cneg <= cval[33];
                r_sneg <= sval[33];
                r_cmag <= cabs;
                r_smag <= sabs;
            end
            OP_MULT: begin
                if (i_cmd.idx[0]) r_acc <= r_acc + {pprod, 21'b0};
                else r_acc <= {21'b0, pprod};
            end
            OP_EMIT: begin
                if (emit) begin
                    r_out_x <= r_pos_x;
                    r_out_y <= r_pos_y;
                    r_out_h <= r_yaw[30:0];
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_x_position = r_out_x;
    assign o_y_position = r_out_y;
    assign o_heading    = r_out_h;

endmodule

FILE: tb/sv/diff_drive_odometry_top_tb.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry_top_tb
// Self-checking bench for the wheel odometry block: ticks go in on the slave
// stream, a local pose predictor builds expected poses, and every pose item
// on the master stream is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
module diff_drive_odometry_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ddo_pkg::*;

    localparam longint PI_Q   = 64'sd843314857;
    localparam longint TWOPI  = 64'sd1686629714;
    localparam longint HALFPI = 64'sd421657428;
    localparam int     STEPS  = 24;
    localparam int     TICK_CYCLES = STEPS + 30;
    localparam longint CYCLE_LIMIT = 64'd2000000;

    typedef struct packed {
        logic signed [30:0] heading;
        logic signed [31:0] y_pos;
        logic signed [31:0] x_pos;
    } t_pose;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // right_count[15:0], left_count[31:16], imu_heading[63:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;   // x_position[31:0], y_position[63:32], heading[94:64]
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [23:0] i_cfg_data;

    diff_drive_odometry_top #(.CORDIC_STEPS(STEPS)) dut (.*);

    // predictor state and configuration copy
    logic [23:0] dist_per_count, turn_per_count;
    logic [8:0]  imu_share;
    logic [7:0]  pose_every, phase_cnt;
    logic [15:0] last_right, last_left;
    longint      odo_yaw;
    logic [31:0] acc_x, acc_y;

    t_pose  pose_queue[$];
    int     error_cnt;
    int     send_idle_pct, recv_idle_pct;
    int     hold_cycles;       // receiver hold-off, counted down by the sink
    longint cycle_cnt;

    // settled atan table (truncated, 2^-30 rad)
    longint atan_tab[30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
        33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63,
        31, 15, 7, 3, 1};

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // floor division by 2^s
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint angle_wrap(longint a);
        longint r;
        r = (a + PI_Q) % TWOPI;
        if (r < 0) r += TWOPI;
        return r - PI_Q;
    endfunction

    function automatic longint count_step(logic [15:0] now, logic [15:0] was);
        logic [15:0] d;
        d = now - was;
        return longint'($signed(d));
    endfunction

    // round(m*t / 2^47) half away from zero, via 128-bit magnitude
    function automatic longint travel_scale(longint m, longint t);
        logic        neg;
        logic [127:0] p;
        neg = (m < 0) != (t < 0);
        p = 128'(m < 0 ? -m : m) * 128'(t < 0 ? -t : t);
        p = (p + (128'd1 << 46)) >> 47;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    task automatic predict_tick(logic [15:0] rc, logic [15:0] lc, logic [31:0] imu);
        longint dr, dl, w, yaw, ang, cx, cy, z, tx, m;
        logic   flip;
        logic [7:0] span;
        t_pose  p;
        dr = count_step(rc, last_right);
        dl = count_step(lc, last_left);
        odo_yaw = angle_wrap(odo_yaw
                             + floor_shift((dr - dl) * longint'(turn_per_count) + 8, 4));
        w = imu_share > 256 ? 256 : longint'(imu_share);
        yaw = floor_shift(w * angle_wrap(longint'($signed(imu))) + (256 - w) * odo_yaw, 8);
        ang = yaw;
        flip = 1'b0;
        if (ang > HALFPI) begin
            ang -= PI_Q; flip = 1'b1;
        end else if (ang < -HALFPI) begin
            ang += PI_Q; flip = 1'b1;
        end
        cx = 652032874; cy = 0; z = ang * 4;
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                tx = cx - floor_shift(cy, i); cy = cy + floor_shift(cx, i);
                z -= atan_tab[i];
            end else begin
                tx = cx + floor_shift(cy, i); cy = cy - floor_shift(cx, i);
                z += atan_tab[i];
            end
            cx = tx;
        end
        if (flip) begin
            cx = -cx; cy = -cy;
        end
        m = (dr + dl) * longint'(dist_per_count);
        acc_x += 32'(travel_scale(m, cx));
        acc_y += 32'(travel_scale(m, cy));
        last_right = rc;
        last_left = lc;
        span = pose_every == 0 ? 8'd1 : pose_every;
        phase_cnt = phase_cnt + 8'd1;
        if (phase_cnt >= span) begin
            phase_cnt = 0;
            p.x_pos = acc_x; p.y_pos = acc_y; p.heading = yaw[30:0];
            pose_queue.push_back(p);
        end
    endtask

    // one tick: idle at random, then hold until accepted
    task automatic send_tick(logic [15:0] rc, logic [15:0] lc, logic [31:0] imu);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {imu, lc, rc};
        // tready is settled at the falling edge; accepted at the next rising one
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        predict_tick(rc, lc, imu);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        i_cfg_we <= 1'b1; i_cfg_addr <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_DISTANCE: dist_per_count = val;
            REG_HEADING:  turn_per_count = val;
            REG_WEIGHT:   imu_share = val[8:0];
            default:      pose_every = val[7:0];
        endcase
        @(posedge i_clk);
    endtask

    // wait for every pose, then let a tick that emits nothing finish
    task automatic drain;
        while (pose_queue.size() != 0) @(posedge i_clk);
        repeat (TICK_CYCLES + 4) @(posedge i_clk);
    endtask

    // pose check: valid and ready are settled at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pose_queue.size() == 0) begin
                $display("%0t pose with none expected: got %h", $time, m_axis_tdata);
                error_cnt++;
            end else begin
                t_pose e;
                e = pose_queue.pop_front();
                if (m_axis_tdata[31:0] !== e.x_pos) begin
                    $display("%0t x: exp %h got %h", $time, e.x_pos, m_axis_tdata[31:0]);
                    error_cnt++;
                end
                if (m_axis_tdata[63:32] !== e.y_pos) begin
                    $display("%0t y: exp %h got %h", $time, e.y_pos, m_axis_tdata[63:32]);
                    error_cnt++;
                end
                if (m_axis_tdata[94:64] !== e.heading) begin
                    $display("%0t heading: exp %h got %h", $time, e.heading,
                             m_axis_tdata[94:64]);
                    error_cnt++;
                end
            end
        end
    end

    // pose sink: random stall or forced hold-off
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic random_tick(int bias);
        logic [15:0] rc, lc;
        logic [31:0] imu;
        // mostly small wheel motion; sometimes anything
        if ($urandom_range(9) < bias) begin
            rc = last_right + 16'($signed($urandom_range(400)) - 200);
            lc = last_left + 16'($signed($urandom_range(400)) - 200);
        end else begin
            rc = 16'($urandom); lc = 16'($urandom);
        end
        imu = ($urandom_range(3) == 0) ? $urandom
              : 32'($signed($urandom_range(1686629713)) - PI_Q);
        send_tick(rc, lc, imu);
    endtask

    task automatic test_directed;
        send_tick(16'd0, 16'd0, 32'd0);
        send_tick(16'd100, 16'd50, 32'h7FFF_FFFF);
        send_tick(16'd65535, 16'd0, 32'h8000_0000);
        send_tick(16'h7FFF, 16'h8000, 32'd843314856);   // half-range jump
        send_tick(16'hFFFF, 16'h0000, 32'hCDBC_3D57);   // just above -pi
        send_tick(16'h7FFE, 16'hFFFF, 32'd421657429);
        drain();
        write_reg(REG_WEIGHT, 24'd0);                    // odometry only
        write_reg(REG_INTERVAL, 24'd1);
        send_tick(16'h8000, 16'h0000, 32'd0);
        send_tick(16'h0000, 16'h8000, 32'd0);
        send_tick(16'h5555, 16'hAAAA, 32'h5555_5555);
        drain();
        write_reg(REG_WEIGHT, 24'd511);                  // clamps to 256
        write_reg(REG_INTERVAL, 24'd0);                  // treated as one
        write_reg(REG_HEADING, 24'hFFFFFF);
        write_reg(REG_DISTANCE, 24'hFFFFFF);
        send_tick(16'hAAAA, 16'h5555, 32'hAAAA_AAAA);
        send_tick(16'h2AAA, 16'hD555, 32'hFFFF_FFFF);
        drain();
        write_reg(REG_INTERVAL, 24'd5);
        send_tick(16'h2AB0, 16'hD550, 32'd1);
        send_tick(16'h2AB8, 16'hD540, 32'd2);
        send_tick(16'h2AC0, 16'hD530, 32'd3);
        drain();
        write_reg(REG_INTERVAL, 24'd2);                  // below phase: next emits
        send_tick(16'h2AC8, 16'hD520, 32'd4);
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) random_tick(8);
    endtask

    task automatic test_backpressure;
        // long receiver hold while ticks keep coming
        hold_cycles = 1500;
        for (int i = 0; i < 12; i++) random_tick(9);
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        m_axis_tready = 1'b0; i_cfg_we = 1'b0; i_cfg_addr = '0; i_cfg_data = '0;
        error_cnt = 0; cycle_cnt = 0; hold_cycles = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        dist_per_count = 24'd168663; turn_per_count = 24'd337326;
        imu_share = 9'd256; pose_every = 8'd2; phase_cnt = 0;
        last_right = 0; last_left = 0; odo_yaw = 0; acc_x = 0; acc_y = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();

        send_idle_pct = 33; recv_idle_pct = 82;
        write_reg(REG_DISTANCE, 24'd168663);
        write_reg(REG_HEADING, 24'd337326);
        write_reg(REG_WEIGHT, 24'd128);
        write_reg(REG_INTERVAL, 24'd1);
        test_random(150);
        drain();                                 // sender pauses for all poses

        send_idle_pct = 82; recv_idle_pct = 33;
        write_reg(REG_DISTANCE, 24'd0);
        write_reg(REG_HEADING, 24'd4000000);
        write_reg(REG_WEIGHT, 24'd256);
        write_reg(REG_INTERVAL, 24'd255);
        test_random(20);
        drain();
        write_reg(REG_DISTANCE, 24'd9000000);
        write_reg(REG_WEIGHT, 24'd37);
        write_reg(REG_INTERVAL, 24'd3);
        test_random(130);
        drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(REG_WEIGHT, 24'd0);
        write_reg(REG_INTERVAL, 24'd1);
        test_random(130);
        drain();

        if (error_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
